// ===== rtl/rle_lz_pkg.sv =====
// Shared types and codes for the RLE/LZ byte decompressor.
`default_nettype none
package rle_lz_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic [1:0] status;
    logic       block_done;
    logic       run_last;
  } out_req_t;

  typedef enum logic [2:0] {
    S_CTRL,
    S_LIT,
    S_RUNVAL,
    S_OFFSET,
    S_EMIT
  } dec_st_e;

  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_ZERO  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_MATCH = 2'd3;

  localparam logic [5:0] N_END = 6'h3F;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_CAP   = 2'd2;
  localparam logic [1:0] STAT_WIN   = 2'd3;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

endpackage
`default_nettype wire

// ===== rtl/rle_lz_byte_decompressor.sv =====
// Top level: control-byte decoder, run/match sequencer and output register.
//
// Input channel (in_valid_i / in_stall_o / in_req_i) takes one compressed byte
// per request. Output channel (out_valid_o / out_stall_i / out_req_o) gives up
// to two decompressed bytes per request plus status, block_done and run_last.
// cfg_we_i writes out_capacity from cfg_wdata_i; write it only while idle.
//
// Control, literal and offset bytes are taken back to back; a result caused by
// such a byte sits in the output register in the cycle after it is taken.
// A zero run, repeat run or match of L bytes then holds the input while the
// sequencer emits it, one result per cycle while the output is not stalled, set
// by the one-pair-per-cycle read/write of the history banks. Matches read the banks
// ahead of each result; a pair just written is forwarded to the next read.
// History is kept in two banks (even/odd byte positions) sized to the next
// power of two at or above HISTORY_DEPTH; it is not cleared at reset.
// Reset empties the output register, sets bytes written to zero and the
// capacity to 65535. A stall on the output holds the sequencer in place and
// stalls the input.
`default_nettype none
module rle_lz_byte_decompressor #(
  parameter int HISTORY_DEPTH = 512
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire rle_lz_pkg::in_req_t  in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output rle_lz_pkg::out_req_t      out_req_o
);
  import rle_lz_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int RW = AW - 1;

  dec_st_e      st_q, st_d;
  logic [15:0]  bw_q, bw_d;
  logic [6:0]   rl_q, rl_d;
  logic [5:0]   rc_q, rc_d;
  logic [6:0]   rem_q, rem_d;
  logic         match_q, match_d;
  logic [7:0]   val_q, val_d;
  logic         lastf_q, lastf_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [15:0]  cap_q;
  logic         out_valid_q;
  out_req_t     out_q;

  logic         load, acc;
  logic [1:0]   op;
  logic [5:0]   n;
  logic [6:0]   len;
  logic         is_end, cap_fail, win_fail, last;
  logic [8:0]   reach;
  logic         cnt2, emit_fire, emit_end;
  logic [6:0]   rem_nxt;
  out_req_t     res;
  logic         res_v;

  logic         wr_we0, wr_we1;
  logic [7:0]   wr_b0, wr_b1;
  logic         re;
  logic [AW-1:0] rd_pos;
  logic [7:0]   rd0, rd1;
  logic [7:0]   em_b0, em_b1;

  logic          we_even, we_odd;
  logic [7:0]    wd_even, wd_odd;
  logic [RW-1:0] wrow_even, wrow_odd, rrow_even, rrow_odd;
  logic [AW-1:0] wpos;

  assign load       = !out_valid_q || !out_stall_i;
  assign in_stall_o = (st_q == S_EMIT) || !load;
  assign acc        = in_valid_i && !in_stall_o;

  assign op       = in_req_i.in_byte[7:6];
  assign n        = in_req_i.in_byte[5:0];
  assign last     = in_req_i.stream_last;
  assign len      = (op == OP_LIT) ? ({1'b0, n} + 7'd1) : ({1'b0, n} + 7'd2);
  assign is_end   = (op == OP_MATCH) && (n == N_END);
  assign cap_fail = ({1'b0, bw_q} + {10'b0, len}) > {1'b0, cap_q};
  assign reach    = {1'b0, in_req_i.in_byte} + 9'd2;
  assign win_fail = {7'b0, reach} > bw_q;

  assign cnt2      = rem_q > 7'd1;
  assign rem_nxt   = rem_q - (cnt2 ? 7'd2 : 7'd1);
  assign emit_fire = (st_q == S_EMIT) && load;
  assign emit_end  = rem_nxt == 7'd0;

  // lane order follows the parity of the first read position
  assign em_b0 = match_q ? (rp_q[0] ? rd1 : rd0) : val_q;
  assign em_b1 = match_q ? (rp_q[0] ? rd0 : rd1) : val_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_CTRL: begin
        if (acc) begin
          if (is_end || cap_fail) begin
            st_d = S_CTRL;
          end else if (op == OP_ZERO) begin
            st_d = S_EMIT;
          end else if (last) begin
            st_d = S_CTRL;
          end else if (op == OP_LIT) begin
            st_d = S_LIT;
          end else if (op == OP_RUN) begin
            st_d = S_RUNVAL;
          end else begin
            st_d = S_OFFSET;
          end
        end
      end
      S_LIT: begin
        if (acc && (last || (rl_q == 7'd1))) begin
          st_d = S_CTRL;
        end
      end
      S_RUNVAL: begin
        if (acc) begin
          st_d = S_EMIT;
        end
      end
      S_OFFSET: begin
        if (acc) begin
          st_d = win_fail ? S_CTRL : S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire && emit_end) begin
          st_d = S_CTRL;
        end
      end
      default: st_d = S_CTRL;
    endcase
  end

  always_comb begin
    bw_d    = bw_q;
    rl_d    = rl_q;
    rc_d    = rc_q;
    rem_d   = rem_q;
    match_d = match_q;
    val_d   = val_q;
    lastf_d = lastf_q;
    rp_d    = rp_q;
    res     = '0;
    res_v   = 1'b0;
    wr_we0  = 1'b0;
    wr_we1  = 1'b0;
    wr_b0   = in_req_i.in_byte;
    wr_b1   = 8'd0;
    re      = 1'b0;
    rd_pos  = rp_q + AW'(2);
    case (st_q)
      S_CTRL: begin
        if (acc) begin
          if (is_end || cap_fail) begin
            res_v          = 1'b1;
            res.status     = is_end ? STAT_OK : STAT_CAP;
            res.block_done = 1'b1;
            res.run_last   = 1'b1;
            bw_d = '0;
            rl_d = '0;
            rc_d = '0;
          end else if (op == OP_ZERO) begin
            rem_d   = len;
            match_d = 1'b0;
            val_d   = 8'd0;
            lastf_d = last;
          end else if (last) begin
            res_v          = 1'b1;
            res.status     = STAT_TRUNC;
            res.block_done = 1'b1;
            res.run_last   = 1'b1;
            bw_d = '0;
            rl_d = '0;
            rc_d = '0;
          end else if (op == OP_LIT) begin
            rl_d = len;
          end else begin
            rc_d = n;
          end
        end
      end
      S_LIT: begin
        if (acc) begin
          wr_we0         = 1'b1;
          bw_d           = bw_q + 16'd1;
          rl_d           = rl_q - 7'd1;
          res_v          = 1'b1;
          res.byte_first = in_req_i.in_byte;
          res.byte_count = 2'd1;
          res.status     = (last && (rl_q != 7'd1)) ? STAT_TRUNC : STAT_OK;
          res.block_done = last;
          res.run_last   = 1'b1;
          if (last) begin
            bw_d = '0;
            rl_d = '0;
            rc_d = '0;
          end
        end
      end
      S_RUNVAL: begin
        if (acc) begin
          rem_d   = {1'b0, rc_q} + 7'd2;
          match_d = 1'b0;
          val_d   = in_req_i.in_byte;
          lastf_d = last;
        end
      end
      S_OFFSET: begin
        if (acc) begin
          if (win_fail) begin
            res_v          = 1'b1;
            res.status     = STAT_WIN;
            res.block_done = 1'b1;
            res.run_last   = 1'b1;
            bw_d = '0;
            rl_d = '0;
            rc_d = '0;
          end else begin
            rem_d   = {1'b0, rc_q} + 7'd2;
            match_d = 1'b1;
            lastf_d = last;
            re      = 1'b1;
            rd_pos  = bw_q[AW-1:0] - AW'(reach);
            rp_d    = rd_pos;
          end
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          wr_we0         = 1'b1;
          wr_we1         = cnt2;
          wr_b0          = em_b0;
          wr_b1          = em_b1;
          res_v          = 1'b1;
          res.byte_first = em_b0;
          res.byte_second = cnt2 ? em_b1 : 8'd0;
          res.byte_count = cnt2 ? 2'd2 : 2'd1;
          res.status     = STAT_OK;
          res.block_done = emit_end && lastf_q;
          res.run_last   = emit_end;
          bw_d           = bw_q + (cnt2 ? 16'd2 : 16'd1);
          rem_d          = rem_nxt;
          if (!emit_end && match_q) begin
            re   = 1'b1;
            rp_d = rd_pos;
          end
          if (emit_end && lastf_q) begin
            bw_d = '0;
            rl_d = '0;
            rc_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // bank mapping: position x lives in bank x[0], row x[AW-1:1]
  assign wpos      = bw_q[AW-1:0];
  assign we_even   = wpos[0] ? wr_we1 : wr_we0;
  assign we_odd    = wpos[0] ? wr_we0 : wr_we1;
  assign wd_even   = wpos[0] ? wr_b1 : wr_b0;
  assign wd_odd    = wpos[0] ? wr_b0 : wr_b1;
  assign wrow_odd  = wpos[AW-1:1];
  assign wrow_even = wpos[AW-1:1] + RW'(wpos[0]);
  assign rrow_odd  = rd_pos[AW-1:1];
  assign rrow_even = rd_pos[AW-1:1] + RW'(rd_pos[0]);

  rle_lz_hist_ram #(
    .ROW_W (RW)
  ) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (wrow_even),
    .wdata_i (wd_even),
    .re_i    (re),
    .raddr_i (rrow_even),
    .rdata_o (rd0)
  );

  rle_lz_hist_ram #(
    .ROW_W (RW)
  ) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (wrow_odd),
    .wdata_i (wd_odd),
    .re_i    (re),
    .raddr_i (rrow_odd),
    .rdata_o (rd1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CTRL;
      bw_q        <= '0;
      rl_q        <= '0;
      rc_q        <= '0;
      rem_q       <= '0;
      match_q     <= 1'b0;
      lastf_q     <= 1'b0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      bw_q    <= bw_d;
      rl_q    <= rl_d;
      rc_q    <= rc_d;
      rem_q   <= rem_d;
      match_q <= match_d;
      lastf_q <= lastf_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load) begin
        out_valid_q <= res_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rp_q  <= rp_d;
    if (load && res_v) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_nobytes_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.byte_count == 2'd0) |-> out_req_o.block_done)
    else $error("status-only result without block end");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status != STAT_OK) |-> out_req_o.block_done)
    else $error("error status without block end");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.block_done |-> out_req_o.run_last)
    else $error("block end not on last result of request");

  a_block_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && res_v && res.block_done |=> (bw_q == 16'd0) && (st_q == S_CTRL))
    else $error("block end did not clear decoder");

  a_emit_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT) |-> (rem_q != 7'd0))
    else $error("run sequencer active with nothing left");

endmodule
`default_nettype wire

// ===== rtl/rle_lz_hist_ram.sv =====
// One bank of the history memory: 1W/1R, registered read, write-first on a row hit.
`default_nettype none
module rle_lz_hist_ram #(
  parameter int ROW_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [ROW_W-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [ROW_W-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  localparam int ROWS = 1 << ROW_W;

  logic [7:0] mem_q [ROWS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
